// ----- design/mvpk_pkg.sv -----
// ----------------------------------------------------------------------------
// MAVLink v2 frame packer package
// Payload types, register indexes, frame constants and the X.25 CRC step
// shared by the packer and its checker.
// ----------------------------------------------------------------------------
package mvpk_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SYSTEM_ID    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPONENT_ID = 1'b1;

   // Register reset values.
   localparam logic [7:0] SYSTEM_ID_RESET    = 8'h01;
   localparam logic [7:0] COMPONENT_ID_RESET = 8'h01;

   // Frame constants.
   localparam logic [7:0]  START_MARKER = 8'hFD;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;

   // One input transfer.
   typedef struct packed {
      logic        first_of_message;
      logic [23:0] message_id;
      logic [7:0]  extra_seed;
      logic [7:0]  payload_length;
      logic [7:0]  payload_byte;
   } req_type;

   // One result transfer.
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_of_frame;
   } rsp_type;

   // Folds one byte into the X.25 (MCRF4XX) CRC.
   function automatic logic [15:0] x25_step(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] t;
      t = b ^ crc[7:0];
      t = t ^ {t[3:0], 4'b0000};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
   endfunction

endpackage

// ----- design/mavlink_v2_frame_packer.sv -----
// ----------------------------------------------------------------------------
// MAVLink v2 frame packer
// Turns a stream of payload bytes into MAVLink v2 frames with X.25 CRC.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one payload byte per transfer. A transfer with
// first_of_message set opens a frame and carries the message id, the CRC
// extra byte and payload length; it also carries the first payload byte when
// the length is nonzero. The rsp channel returns the frame one byte per
// transfer, with last_of_frame set on the CRC high byte. Stray payload bytes
// with no frame open are dropped. The csr port sets the system and component ids.
// Timing: an accepted transfer sits in an input register and one frame byte
// is produced per cycle into the output register while rsp does not stall;
// a result byte is valid once registered there. A first transfer produces
// the header bytes, its payload byte when the length is nonzero and the CRC
// bytes when it closes the frame; a payload transfer, its byte and the CRC
// bytes when it closes the frame; a dropped one, none. The next transfer is
// taken in the cycle the last byte of the current one moves to the output
// register. Reset clears both channels, the open frame and the sequence
// number, and sets both ids to 1. A stall on rsp holds the output byte and
// pauses the byte sequencer; req_stall then rises once an undropped transfer is held.
module mavlink_v2_frame_packer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  mvpk_pkg::req_type                   req_data,
   output logic                                req_stall,
   output logic                                rsp_valid,
   output mvpk_pkg::rsp_type                   rsp_data,
   input  logic                                rsp_stall,
   input  logic                                csr_wr_en,
   input  logic [mvpk_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mvpk_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mvpk_pkg::*;

   // Position within the bytes that the held item produces.
   typedef enum logic [3:0] {
      ST_MARK, ST_LEN, ST_FLAG0, ST_FLAG1, ST_SEQ, ST_SYS, ST_COMP,
      ST_ID0, ST_ID1, ST_ID2, ST_PAYLOAD, ST_CRC_LO, ST_CRC_HI
   } step_type;

   logic [7:0]  sys_id_ff;
   logic [7:0]  comp_id_ff;
   logic        hold_vld_ff;
   req_type     hold_ff;
   step_type    step_ff;
   step_type    step_in;
   logic [7:0]  seq_ff;
   logic [15:0] crc_ff;
   logic [7:0]  rem_ff;
   logic        open_ff;
   logic [7:0]  extra_ff;
   logic        rsp_vld_ff;
   rsp_type     rsp_ff;

   logic        out_free;
   logic        drop;
   logic        emit;
   logic        step_last;
   logic        item_done;
   logic        accept;
   logic [7:0]  byte_out;
   logic        last_out;
   logic [15:0] crc_hash;
   logic [15:0] crc_fin;

   // Handshake decisions for the held item.
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign drop      = hold_vld_ff && !hold_ff.first_of_message && !open_ff;
   assign emit      = hold_vld_ff && !drop && out_free;
   assign item_done = drop || (emit && step_last);
   assign req_stall = hold_vld_ff && !item_done;
   assign accept    = req_valid && !req_stall;

   assign crc_hash = x25_step(crc_ff, byte_out);
   assign crc_fin  = x25_step(crc_ff, extra_ff);

   // Byte selection and next position.
   always_comb begin
      byte_out  = 8'h00;
      last_out  = 1'b0;
      step_last = 1'b0;
      step_in   = ST_MARK;
      case (step_ff)
         ST_MARK: begin
            byte_out = START_MARKER;
            step_in  = ST_LEN;
         end
         ST_LEN: begin
            byte_out = hold_ff.payload_length;
            step_in  = ST_FLAG0;
         end
         ST_FLAG0: begin
            step_in = ST_FLAG1;
         end
         ST_FLAG1: begin
            step_in = ST_SEQ;
         end
         ST_SEQ: begin
            byte_out = seq_ff;
            step_in  = ST_SYS;
         end
         ST_SYS: begin
            byte_out = sys_id_ff;
            step_in  = ST_COMP;
         end
         ST_COMP: begin
            byte_out = comp_id_ff;
            step_in  = ST_ID0;
         end
         ST_ID0: begin
            byte_out = hold_ff.message_id[7:0];
            step_in  = ST_ID1;
         end
         ST_ID1: begin
            byte_out = hold_ff.message_id[15:8];
            step_in  = ST_ID2;
         end
         ST_ID2: begin
            byte_out = hold_ff.message_id[23:16];
            step_in  = (hold_ff.payload_length == 8'h00) ? ST_CRC_LO : ST_PAYLOAD;
         end
         ST_PAYLOAD: begin
            byte_out  = hold_ff.payload_byte;
            step_in   = ST_CRC_LO;
            step_last = (rem_ff != 8'h01);
         end
         ST_CRC_LO: begin
            byte_out = crc_fin[7:0];
            step_in  = ST_CRC_HI;
         end
         ST_CRC_HI: begin
            byte_out  = crc_ff[15:8];
            last_out  = 1'b1;
            step_last = 1'b1;
         end
         default: begin
            step_last = 1'b1;
         end
      endcase
   end

   // Frame state, input register and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sys_id_ff   <= SYSTEM_ID_RESET;
         comp_id_ff  <= COMPONENT_ID_RESET;
         hold_vld_ff <= 1'b0;
         step_ff     <= ST_MARK;
         seq_ff      <= 8'h00;
         crc_ff      <= CRC_INIT;
         rem_ff      <= 8'h00;
         open_ff     <= 1'b0;
         extra_ff    <= 8'h00;
         rsp_vld_ff  <= 1'b0;
      end else begin
         // Configuration writes.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SYSTEM_ID:    sys_id_ff  <= csr_wdata;
               CSR_COMPONENT_ID: comp_id_ff <= csr_wdata;
               default: ;
            endcase
         end

         // One frame byte per cycle while the output register has room.
         if (emit) begin
            case (step_ff)
               ST_MARK: begin
                  crc_ff   <= CRC_INIT;
                  extra_ff <= hold_ff.extra_seed;
                  rem_ff   <= hold_ff.payload_length;
                  open_ff  <= 1'b1;
               end
               ST_SEQ: begin
                  crc_ff <= crc_hash;
                  seq_ff <= seq_ff + 8'h01;
               end
               ST_PAYLOAD: begin
                  crc_ff <= crc_hash;
                  rem_ff <= rem_ff - 8'h01;
               end
               ST_CRC_LO: begin
                  crc_ff <= crc_fin;
               end
               ST_CRC_HI: begin
                  crc_ff  <= CRC_INIT;
                  rem_ff  <= 8'h00;
                  open_ff <= 1'b0;
               end
               default: begin
                  crc_ff <= crc_hash;
               end
            endcase
         end

         // Input register: a new transfer starts at the marker or at its payload byte.
         // Otherwise the position advances with each emitted byte.
         if (accept) begin
            hold_ff     <= req_data;
            hold_vld_ff <= 1'b1;
            step_ff     <= req_data.first_of_message ? ST_MARK : ST_PAYLOAD;
         end else begin
            if (emit) begin
               step_ff <= step_in;
            end
            if (item_done) begin
               hold_vld_ff <= 1'b0;
            end
         end

         // Output register.
         if (emit) begin
            rsp_vld_ff           <= 1'b1;
            rsp_ff.frame_byte    <= byte_out;
            rsp_ff.last_of_frame <= last_out;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/mvpk_checker.sv -----
// ----------------------------------------------------------------------------
// MAVLink v2 frame packer checker
// Port-level assertions on the packer's channels, bound to the top level.
// ----------------------------------------------------------------------------
module mvpk_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input mvpk_pkg::rsp_type rsp_data,
   input logic              rsp_stall
);
   import mvpk_pkg::*;

   logic rsp_xfer;
   logic after_last_ff;

   assign rsp_xfer = rsp_valid && !rsp_stall;

   // Set while the next result transfer must open a new frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         after_last_ff <= 1'b1;
      end else if (rsp_xfer) begin
         after_last_ff <= rsp_data.last_of_frame;
      end
   end

   // A stalled result stays valid.
   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled result keeps its payload.
   a_rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // Every frame begins with the start marker.
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && after_last_ff |-> rsp_data.frame_byte == START_MARKER)
      else $error("frame did not begin with the start marker");

   // Reset empties both sides.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind mavlink_v2_frame_packer mvpk_checker u_mvpk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .rsp_stall (rsp_stall)
);
